// ----- design/tbd_pkg.sv -----
// Package for the touch button dispatch block: entry record, hit-test
// status and the function, event and kind codes.
// No dependencies.
package tbd_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_TOUCH = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_CANCEL  = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    // Widget kind that responds to touches
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    // One widget table entry as held in the entry memory
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic        enable;
        logic        pressed;
    } t_entry;

    // Hit-test status handed from the hit tester to the sequencer
    typedef struct packed {
        logic in_rect;     // point within the rectangle
        logic claimable;   // enabled button
    } t_hit;

endpackage

// ----- design/touch_button_dispatch.sv -----
// Add, clear and no-op items are answered from dispatch; a held or lifted touch on an
// active button first reads its entry, and a new touch scans entries newest first.
// The next transaction is taken the cycle after the result is loaded, so an item is
// accepted only once the last one is done; a full output register holds the load back.
// Reset (sync, active low) empties the table and frees the active slot; entry memory
// is left undefined and no clearing pass runs. Depends on tbd_pkg and tbd_hit_test.
module touch_button_dispatch
    import tbd_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_touch_x,
    input  logic [15:0] i_touch_y,
    input  logic        i_touching,
    input  logic [1:0]  i_widget_kind,
    input  logic [15:0] i_rect_left,
    input  logic [15:0] i_rect_top,
    input  logic [15:0] i_rect_width,
    input  logic [15:0] i_rect_height,
    input  logic        i_enable_flag,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_code,
    output logic [3:0]  o_entry_index,
    output logic        o_shown_pressed,
    output logic        o_redraw,
    output logic        o_add_accepted
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SCAN     = 5'b00100,
        S_HELD     = 5'b01000,
        S_LIFT     = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // control state
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_active_valid, n_active_valid;
    logic [IDX_W-1:0] r_active_slot, n_active_slot;
    logic [IDX_W-1:0] r_ptr, n_ptr;

    // captured transaction
    logic [1:0]  r_func;
    logic [15:0] r_x, r_y;
    logic        r_touching;
    logic [1:0]  r_kind;
    logic [15:0] r_left, r_top, r_width, r_height;
    logic        r_enable;

    // entry memory, registered read
    t_entry           r_mem [MAX_ENTRIES];
    t_entry           r_rd_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_entry           w_wr_data;

    // result path
    logic             r_out_valid;
    logic [1:0]       r_out_ev;
    logic [3:0]       r_out_idx;
    logic             r_out_shown;
    logic             r_out_redraw;
    logic             r_out_acc;
    logic             w_out_free;
    logic             w_load;
    logic [1:0]       w_res_ev;
    logic [IDX_W-1:0] w_res_idx;
    logic [IDX_W+3:0] w_res_idx_ext;
    logic             w_res_shown;
    logic             w_res_redraw;
    logic             w_res_acc;

    logic [CNT_W-1:0] w_count_m1;
    logic [IDX_W-1:0] w_last;
    t_hit             w_hit;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_last     = w_count_m1[IDX_W-1:0];

    // Hit test on the entry just read
    tbd_hit_test u_hit (
        .i_entry (r_rd_data),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_hit   (w_hit)
    );

    // Capture the transaction payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func     <= i_func;
            r_x        <= i_touch_x;
            r_y        <= i_touch_y;
            r_touching <= i_touching;
            r_kind     <= i_widget_kind;
            r_left     <= i_rect_left;
            r_top      <= i_rect_top;
            r_width    <= i_rect_width;
            r_height   <= i_rect_height;
            r_enable   <= i_enable_flag;
        end
    end

    // Entry memory: one write port, one read port.
    // Writes only happen when a transaction finishes, before the next transaction
    // passes through the idle state and reads, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_active_valid = r_active_valid;
        n_active_slot  = r_active_slot;
        n_ptr          = r_ptr;
        w_rd_en        = 1'b0;
        w_rd_addr      = r_ptr;
        w_wr_en        = 1'b0;
        w_wr_addr      = r_ptr;
        w_wr_data      = r_rd_data;
        w_load         = 1'b0;
        w_res_ev       = EV_NONE;
        w_res_idx      = '0;
        w_res_shown    = 1'b0;
        w_res_redraw   = 1'b0;
        w_res_acc      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                if (r_func == FUNC_TOUCH && r_active_valid) begin
                    // held or lifted: fetch the active entry
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_active_slot;
                    n_state   = r_touching ? S_HELD : S_LIFT;
                end else if (r_func == FUNC_TOUCH && r_touching && r_count != '0) begin
                    // new touch: scan from the newest entry
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_last;
                    n_ptr     = w_last;
                    n_state   = S_SCAN;
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (r_func == FUNC_ADD && r_count < CNT_W'(MAX_ENTRIES)) begin
                        w_wr_en           = 1'b1;
                        w_wr_addr         = r_count[IDX_W-1:0];
                        w_wr_data.kind    = r_kind;
                        w_wr_data.left    = r_left;
                        w_wr_data.top     = r_top;
                        w_wr_data.width   = r_width;
                        w_wr_data.height  = r_height;
                        w_wr_data.enable  = r_enable;
                        w_wr_data.pressed = 1'b0;
                        w_res_idx         = r_count[IDX_W-1:0];
                        w_res_acc         = 1'b1;
                        n_count           = r_count + CNT_W'(1);
                    end else if (r_func == FUNC_CLEAR) begin
                        n_count        = '0;
                        n_active_valid = 1'b0;
                        n_active_slot  = '0;
                    end
                end
            end

            S_SCAN: begin
                if (w_hit.claimable && w_hit.in_rect) begin
                    // claim this button
                    if (w_out_free) begin
                        w_load            = 1'b1;
                        n_state           = S_IDLE;
                        w_wr_en           = 1'b1;
                        w_wr_addr         = r_ptr;
                        w_wr_data.pressed = 1'b1;
                        w_res_redraw      = !r_rd_data.pressed;
                        w_res_ev          = r_rd_data.pressed ? EV_NONE : EV_PRESS;
                        w_res_idx         = r_ptr;
                        w_res_shown       = 1'b1;
                        n_active_valid    = 1'b1;
                        n_active_slot     = r_ptr;
                    end
                end else if (r_ptr == '0) begin
                    // nothing hit
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_ptr - IDX_W'(1);
                    n_ptr     = r_ptr - IDX_W'(1);
                end
            end

            S_HELD: begin
                if (w_out_free) begin
                    w_load            = 1'b1;
                    n_state           = S_IDLE;
                    w_wr_en           = 1'b1;
                    w_wr_addr         = r_active_slot;
                    w_wr_data.pressed = w_hit.in_rect;
                    w_res_redraw      = (r_rd_data.pressed != w_hit.in_rect);
                    if (r_rd_data.pressed != w_hit.in_rect) begin
                        w_res_ev = w_hit.in_rect ? EV_PRESS : EV_CANCEL;
                    end
                    w_res_idx         = r_active_slot;
                    w_res_shown       = w_hit.in_rect;
                end
            end

            S_LIFT: begin
                if (w_out_free) begin
                    w_load            = 1'b1;
                    n_state           = S_IDLE;
                    w_wr_en           = 1'b1;
                    w_wr_addr         = r_active_slot;
                    w_wr_data.pressed = 1'b0;
                    w_res_ev          = r_rd_data.pressed ? EV_RELEASE : EV_CANCEL;
                    w_res_redraw      = r_rd_data.pressed;
                    w_res_idx         = r_active_slot;
                    n_active_valid    = 1'b0;
                    n_active_slot     = '0;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_active_valid <= 1'b0;
            r_active_slot  <= '0;
            r_ptr          <= '0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_active_valid <= n_active_valid;
            r_active_slot  <= n_active_slot;
            r_ptr          <= n_ptr;
        end
    end

    // Output register
    assign w_res_idx_ext = {4'b0000, w_res_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ev     <= w_res_ev;
            r_out_idx    <= w_res_idx_ext[3:0];
            r_out_shown  <= w_res_shown;
            r_out_redraw <= w_res_redraw;
            r_out_acc    <= w_res_acc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_code    = r_out_ev;
    assign o_entry_index   = r_out_idx;
    assign o_shown_pressed = r_out_shown;
    assign o_redraw        = r_out_redraw;
    assign o_add_accepted  = r_out_acc;

`ifndef SYNTHESIS
    // Table never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // The active button is always a stored entry
    a_active_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_valid |-> (CNT_W'(r_active_slot) < r_count))
        else $error("active slot outside the table");

    // An accepted transaction always goes to dispatch next
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISPATCH))
        else $error("accepted transaction not dispatched");

    // Add results carry no touch event
    a_add_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_add_accepted) |-> (o_event_code == EV_NONE && !o_redraw))
        else $error("add result carries an event");
`endif

endmodule

// ----- design/tbd_hit_test.sv -----
// Rectangle hit test for one widget entry, edges wrap at 16 bits.
// Depends on tbd_pkg.
module tbd_hit_test
    import tbd_pkg::*;
(
    input  t_entry      i_entry,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    output t_hit        o_hit
);

    logic [15:0] w_right;
    logic [15:0] w_bottom;

    // Far edges, sums truncated to 16 bits
    assign w_right  = i_entry.left + i_entry.width;
    assign w_bottom = i_entry.top + i_entry.height;

    assign o_hit.in_rect = (i_x >= i_entry.left) && (i_x < w_right) &&
                           (i_y >= i_entry.top) && (i_y < w_bottom);
    assign o_hit.claimable = (i_entry.kind == KIND_BUTTON) && i_entry.enable;

endmodule
